[rtl/core/pal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg: shared types and defaults for the positional array list
// operation codes, status codes and the per-cell action broadcast
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int ELEM_WIDTH_DEF = 32;

	// operation carried by each input transfer
	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_APPEND   = 3'd2,
		OP_GET_NEXT = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// action broadcast to every cell of the row
	typedef enum logic [2:0] {
		ACT_HOLD   = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_DELETE = 3'd2,
		ACT_APPEND = 3'd3,
		ACT_CLEAR  = 3'd4
	} cell_act_t;

endpackage

[rtl/core/pal_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell: one list entry
// holds one element and trades it with its neighbours on insert and delete
// ----------------------------------------------------------------------------
module pal_cell #(
	parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF,
	parameter int IDX        = 0,
	localparam int IW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pal_pkg::cell_act_t    act,
	input  logic [IW-1:0]         tgt,
	input  logic [ELEM_WIDTH-1:0] new_elem,
	input  logic [ELEM_WIDTH-1:0] left_elem,
	input  logic [ELEM_WIDTH-1:0] right_elem,
	output logic [ELEM_WIDTH-1:0] elem
);
	import pal_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [ELEM_WIDTH-1:0] elem_q;
	logic [ELEM_WIDTH-1:0] elem_d;

	always_comb begin
		elem_d = elem_q;
		case (act)
			ACT_INSERT: begin
				if (MY_IDX > tgt) begin
					elem_d = left_elem;
				end else if (MY_IDX == tgt) begin
					elem_d = new_elem;
				end
			end
			ACT_DELETE: begin
				if (MY_IDX >= tgt) begin
					elem_d = right_elem;
				end
			end
			ACT_APPEND: begin
				if (MY_IDX == tgt) begin
					elem_d = new_elem;
				end
			end
			ACT_CLEAR: begin
				elem_d = '0;
			end
			default: begin
				elem_d = elem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= '0;
		end else begin
			elem_q <= elem_d;
		end
	end

	assign elem = elem_q;

endmodule

[rtl/core/pal_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl: operation decode and element count
// checks the position against the count, picks the cell action, keeps count
// ----------------------------------------------------------------------------
module pal_ctrl #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
	localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [2:0]         op,
	input  logic [4:0]         position,
	output pal_pkg::cell_act_t act,
	output logic [IW-1:0]      tgt,
	output logic               rd_en,
	output pal_pkg::status_t   status,
	output logic [CW-1:0]      count_next
);
	import pal_pkg::*;

	// compare width covers both the position field and the count
	localparam int PW = ((CW > 5) ? CW : 5) + 1;
	localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

	logic [CW-1:0] count_q;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	cell_act_t     act_dec;

	assign pos_w = PW'(position);
	assign cnt_w = PW'(count_q);

	always_comb begin
		act_dec    = ACT_HOLD;
		tgt        = '0;
		rd_en      = 1'b0;
		status     = ST_OK;
		count_next = count_q;
		case (op_t'(op))
			OP_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
					status = ST_RANGE;
				end else if (cnt_w >= CAP_W) begin
					status = ST_FULL;
				end else begin
					act_dec    = ACT_INSERT;
					tgt        = IW'(pos_w - PW'(1));
					count_next = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					status = ST_RANGE;
				end else begin
					act_dec    = ACT_DELETE;
					tgt        = IW'(pos_w - PW'(1));
					count_next = count_q - CW'(1);
				end
			end
			OP_APPEND: begin
				if (cnt_w >= CAP_W) begin
					status = ST_FULL;
				end else begin
					act_dec    = ACT_APPEND;
					tgt        = IW'(count_q);
					count_next = count_q + CW'(1);
				end
			end
			OP_GET_NEXT: begin
				if (pos_w == '0 || pos_w + PW'(1) > cnt_w) begin
					status = ST_RANGE;
				end else begin
					rd_en = 1'b1;
					tgt   = IW'(pos_w);
				end
			end
			OP_CLEAR: begin
				act_dec    = ACT_CLEAR;
				count_next = '0;
			end
			default: begin
				act_dec = ACT_HOLD;
			end
		endcase
	end

	// cells only move on an accepted transfer
	assign act = fire ? act_dec : ACT_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

endmodule

[rtl/core/positional_array_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list: ordered list held in a row of shifting cells
// insert, delete, append, get next and clear on a 1-based position
// ----------------------------------------------------------------------------
//  channel  | direction | fields (lowest bit first)
//  s_*      | in        | op[2:0], position[7:3], value[39:8]
//  m_*      | out       | status[1:0], read_value[33:2], count[38:34], pad[39]
//
//  one transfer per cycle while s_tready is high: each cell loads from its left
//  or right neighbour, the new value or holds, all in the cycle the transfer is accepted
//  the result appears in the output register in the cycle after acceptance
//  s_tready is high while the output register is empty or being drained
//  reset empties the list and zeroes every cell; no clearing pass is needed
// ----------------------------------------------------------------------------
module positional_array_list #(
	parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // op[2:0], position[7:3], value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[1:0], read_value[33:2], count[38:34], zero[39]
);
	import pal_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// input fields
	logic [2:0]  in_op;
	logic [4:0]  in_pos;
	logic [31:0] in_value;
	logic [63:0] value_wide;
	logic [ELEM_WIDTH-1:0] new_elem;

	assign in_op    = s_tdata[2:0];
	assign in_pos   = s_tdata[7:3];
	assign in_value = s_tdata[39:8];
	// keep only the low ELEM_WIDTH bits of the value
	assign value_wide = 64'(in_value);
	assign new_elem   = value_wide[ELEM_WIDTH-1:0];

	logic fire;
	assign fire = s_tvalid & s_tready;

	// decode and count
	cell_act_t     act;
	logic [IW-1:0] tgt;
	logic          rd_en;
	status_t       status;
	logic [CW-1:0] count_next;

	pal_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (in_op),
		.position   (in_pos),
		.act        (act),
		.tgt        (tgt),
		.rd_en      (rd_en),
		.status     (status),
		.count_next (count_next)
	);

	// row of cells, entry 0 on the left
	logic [ELEM_WIDTH-1:0] elem [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_elem;
		logic [ELEM_WIDTH-1:0] right_elem;

		if (i == 0) begin : g_first
			assign left_elem = '0;
		end else begin : g_mid_l
			assign left_elem = elem[i-1];
		end

		// the last cell takes zero when the list closes up
		if (i == CAPACITY - 1) begin : g_last
			assign right_elem = '0;
		end else begin : g_mid_r
			assign right_elem = elem[i+1];
		end

		pal_cell #(
			.CAPACITY   (CAPACITY),
			.ELEM_WIDTH (ELEM_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.act        (act),
			.tgt        (tgt),
			.new_elem   (new_elem),
			.left_elem  (left_elem),
			.right_elem (right_elem),
			.elem       (elem[i])
		);
	end

	// get next reads the cell after the given position, before any update
	logic [ELEM_WIDTH-1:0] rd_elem;
	logic [63:0]           rd_wide;
	logic [31:0]           rd_value;

	assign rd_elem  = rd_en ? elem[tgt] : '0;
	assign rd_wide  = 64'(rd_elem);
	assign rd_value = rd_wide[31:0];

	// output register, refilled in the same cycle it drains
	logic        m_valid_q;
	logic [39:0] m_data_q;

	assign s_tready = ~m_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= {1'b0, 5'(count_next), rd_value, status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

[rtl/core/pal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_checker: port-level checks for the positional array list
// watches both stream channels and the result fields over time
// ----------------------------------------------------------------------------
module pal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	import pal_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted transfer gives a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted transfer");

	// a failed operation reads nothing
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[33:2] == 32'd0)
		else $error("read value on failed operation");

	// clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[2:0] == OP_CLEAR
		|=> m_tdata[38:34] == 5'd0 && m_tdata[1:0] == ST_OK)
		else $error("clear left a count");

	// status never holds the unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("bad status code");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
